// ===== rtl/core/lz78pd_pkg.sv =====
package lz78pd_pkg;

  localparam int LETTER_W = 8;
  localparam int PARENT_W = 12;

  // address width of a memory, at least one bit
  function automatic int addr_width(input int depth);
    addr_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [PARENT_W-1:0] parent;
  } dict_entry_t;

endpackage

// ===== rtl/core/lz78pd_ram.sv =====
module lz78pd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [lz78pd_pkg::addr_width(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [lz78pd_pkg::addr_width(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  import lz78pd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lz78_phrase_decoder_core.sv =====
// lz78 phrase decoder: one phrase (parent index, letter) per start, bytes out in text order
// a phrase of n bytes (n up to MAX_DEPTH) takes n-1 link reads in the walk state, one store
//   of the new entry, then its n bytes in the emit state
// one phrase at a time, a new start is taken only once idle again; errors: a bad parent, a full
//   table or a chain too deep give one error result; results cannot be stalled
// reset (rst, synchronous) returns to idle and sets the next free index to 1; memories keep contents
module lz78_phrase_decoder_core #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_DEPTH     = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lz78pd_pkg::PARENT_W-1:0] parent_index,
  input  logic [lz78pd_pkg::LETTER_W-1:0] letter,
  output logic                            strobe,
  output logic [lz78pd_pkg::LETTER_W-1:0] out_byte,
  output logic                            last,
  output logic                            error
);
  import lz78pd_pkg::*;

  // widths derived from the parameters
  localparam int IW   = addr_width(TABLE_ENTRIES);   // dictionary address
  localparam int NW   = $clog2(TABLE_ENTRIES + 1);   // next free index, can reach TABLE_ENTRIES
  localparam int RW   = addr_width(MAX_DEPTH);       // reverse buffer address
  localparam int CW   = $clog2(MAX_DEPTH + 1);       // letters gathered so far
  localparam int CMPW = (NW > PARENT_W) ? NW : PARENT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_STORE,
    S_EMIT,
    S_ERR
  } state_t;

  state_t               state;
  logic [NW-1:0]        next_index;
  logic [CW-1:0]        count;
  logic [RW-1:0]        ptr;
  logic [LETTER_W-1:0]  cur_letter;
  logic [PARENT_W-1:0]  cur_parent;

  // dictionary port signals
  dict_entry_t          dict_rd;
  dict_entry_t          dict_wr;
  logic                 dict_we;
  logic [IW-1:0]        dict_raddr;

  // reverse buffer port signals
  logic                 rb_we;
  logic [RW-1:0]        rb_waddr;
  logic [LETTER_W-1:0]  rb_wdata;
  logic [RW-1:0]        rb_raddr;
  logic [LETTER_W-1:0]  rb_rdata;

  logic                 accept;
  logic                 table_full;
  logic                 bad_parent;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        count_m1;

  assign accept     = start && (state == S_IDLE);
  assign table_full = next_index >= NW'(TABLE_ENTRIES);
  assign bad_parent = CMPW'(parent_index) >= CMPW'(next_index);
  assign count_inc  = count + CW'(1);
  assign count_m1   = count - CW'(1);

  // one link per cycle: the parent just read is the next read address
  always_comb begin
    dict_raddr = IW'(parent_index);
    rb_raddr   = count_m1[RW-1:0];
    rb_we      = 1'b0;
    rb_waddr   = count[RW-1:0];
    rb_wdata   = dict_rd.letter;
    case (state)
      S_IDLE: begin
        dict_raddr = IW'(parent_index);
        rb_we      = accept;
        rb_waddr   = '0;
        rb_wdata   = letter;
      end
      S_WALK: begin
        dict_raddr = IW'(dict_rd.parent);
        rb_we      = 1'b1;
      end
      S_STORE: begin
        rb_raddr = count_m1[RW-1:0];
      end
      S_EMIT: begin
        rb_raddr = ptr - RW'(1);
      end
      default: begin
        rb_we = 1'b0;
      end
    endcase
  end

  // the new entry goes in only once the whole chain checked out
  assign dict_we        = (state == S_STORE);
  assign dict_wr.letter = cur_letter;
  assign dict_wr.parent = cur_parent;

  lz78pd_ram #(
    .WIDTH ($bits(dict_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (IW'(next_index)),
    .wdata (dict_wr),
    .raddr (dict_raddr),
    .rdata (dict_rd)
  );

  lz78pd_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_DEPTH)
  ) u_rbuf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_index <= NW'(1);
      count      <= '0;
      ptr        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_letter <= letter;
            cur_parent <= parent_index;
            count      <= CW'(1);
            if (table_full || bad_parent) begin
              state <= S_ERR;
            end else if (parent_index == '0) begin
              state <= S_STORE;
            end else if (MAX_DEPTH <= 1) begin
              // the new letter alone already fills the buffer
              state <= S_ERR;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          count <= count_inc;
          if (dict_rd.parent == '0) begin
            state <= S_STORE;
          end else if (count_inc >= CW'(MAX_DEPTH)) begin
            // chain deeper than the buffer holds
            state <= S_ERR;
          end
        end
        S_STORE: begin
          next_index <= next_index + NW'(1);
          ptr        <= count_m1[RW-1:0];
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (ptr == '0) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr - RW'(1);
          end
        end
        S_ERR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // bytes come straight off the registered buffer read, oldest letter first
  assign busy     = (state != S_IDLE);
  assign strobe   = (state == S_EMIT) || (state == S_ERR);
  assign error    = (state == S_ERR);
  assign last     = (state == S_ERR) || ((state == S_EMIT) && (ptr == '0));
  assign out_byte = (state == S_EMIT) ? rb_rdata : '0;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result transfer while idle");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && error) |-> last)
    else $error("error result not marked last");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("still busy after final transfer");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted phrase left no work");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (next_index != '0) && (next_index <= NW'(TABLE_ENTRIES)))
    else $error("next free index out of range");

endmodule
